### sv/handheld_bus_address_decoder_top_macros.svh
// Assertion macros for the handheld bus address decoder.
// Used by handheld_bus_address_decoder_top; expects aclk and aresetn in scope.
`ifndef HANDHELD_BUS_ADDRESS_DECODER_TOP_MACROS_SVH
`define HANDHELD_BUS_ADDRESS_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HBAD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("decoder check failed");

// Next-cycle implication, checked outside reset.
`define HBAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("decoder check failed");

`endif

### sv/hbad_pkg.sv
// Package for the handheld bus address decoder: memory sizes, region and
// target codes, address bounds and the result record. No dependencies.
package hbad_pkg;

    localparam int EWRAM_BYTES       = 262144;
    localparam int IWRAM_BYTES       = 32768;
    localparam int SRAM_BYTES        = 65536;
    localparam int PALETTE_BYTES     = 1024;
    localparam int OAM_BYTES         = 1024;
    localparam int VRAM_MIRROR_BYTES = 131072;

    localparam int OFF_W   = 25;
    localparam int TDATA_W = 104;

    localparam logic [OFF_W-1:0] EWRAM_MASK   = OFF_W'(EWRAM_BYTES - 1);
    localparam logic [OFF_W-1:0] IWRAM_MASK   = OFF_W'(IWRAM_BYTES - 1);
    localparam logic [OFF_W-1:0] SRAM_MASK    = OFF_W'(SRAM_BYTES - 1);
    localparam logic [OFF_W-1:0] PALETTE_MASK = OFF_W'(PALETTE_BYTES - 1);
    localparam logic [OFF_W-1:0] OAM_MASK     = OFF_W'(OAM_BYTES - 1);
    localparam logic [OFF_W-1:0] VRAM_MASK    = OFF_W'(VRAM_MIRROR_BYTES - 1);
    localparam logic [OFF_W-1:0] IO_MASK      = 25'h0FF_FFFF;

    localparam logic [OFF_W-1:0] VRAM_FOLD_START = 25'h0_18000;
    localparam logic [OFF_W-1:0] VRAM_FOLD_SIZE  = 25'h0_08000;

    localparam logic [31:0] BIOS_LIMIT     = 32'h0000_3FFF;
    localparam logic [31:0] VRAM_BASE      = 32'h0600_0000;
    localparam logic [31:0] VRAM_HOLE_LO   = 32'h0601_8000;
    localparam logic [31:0] VRAM_HOLE_HI   = 32'h0601_BFFF;
    localparam logic [31:0] OBJ_BITMAP_LO  = 32'h0601_4000;
    localparam logic [31:0] OBJ_LO         = 32'h0601_0000;
    localparam logic [31:0] OBJ_HI         = 32'h0601_7FFF;
    localparam logic [31:0] BG_BITMAP_HI   = 32'h0601_3FFF;
    localparam logic [31:0] BG_HI          = 32'h0600_FFFF;

    localparam logic [7:0] REGION_BIOS   = 8'h00;
    localparam logic [7:0] REGION_EWRAM  = 8'h02;
    localparam logic [7:0] REGION_IWRAM  = 8'h03;
    localparam logic [7:0] REGION_IO     = 8'h04;
    localparam logic [7:0] REGION_PAL    = 8'h05;
    localparam logic [7:0] REGION_VRAM   = 8'h06;
    localparam logic [7:0] REGION_OAM    = 8'h07;
    localparam logic [7:0] REGION_CART0A = 8'h08;
    localparam logic [7:0] REGION_CART0B = 8'h09;
    localparam logic [7:0] REGION_CART1A = 8'h0A;
    localparam logic [7:0] REGION_CART1B = 8'h0B;
    localparam logic [7:0] REGION_CART2A = 8'h0C;
    localparam logic [7:0] REGION_CART2B = 8'h0D;
    localparam logic [7:0] REGION_SRAMA  = 8'h0E;
    localparam logic [7:0] REGION_SRAMB  = 8'h0F;

    localparam logic [2:0] BYTE_SIZE = 3'd1;
    localparam logic [2:0] HALF_SIZE = 3'd2;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_DATA  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        TGT_NONE  = 4'd0,
        TGT_BIOS  = 4'd1,
        TGT_EWRAM = 4'd2,
        TGT_IWRAM = 4'd3,
        TGT_IO    = 4'd4,
        TGT_PAL   = 4'd5,
        TGT_VRAM  = 4'd6,
        TGT_OAM   = 4'd7,
        TGT_CART  = 4'd8,
        TGT_SRAM  = 4'd9
    } tgt_t;

    // Declared high field first so that target lands in the lowest bits.
    typedef struct packed {
        logic [31:0]      return_data;
        logic             access_dropped;
        logic             bios_privileged;
        logic [31:0]      out_data;
        logic [2:0]       out_bytes;
        logic [OFF_W-1:0] local_offset;
        tgt_t             target;
    } res_t;

    localparam int RES_PAD = TDATA_W - $bits(res_t);

endpackage

### sv/handheld_bus_address_decoder_top.sv
// Handheld bus address decoder: input register, one level of decode logic,
// result register. Depends on hbad_pkg and the assertion macro header.
// The result register loads from the input register when the output can take it,
// and m_tvalid rises with it. One request per cycle while m_tready is high.
// Reset (aresetn low, synchronous) empties both stages and clears the
// open-bus latch and its pending flag.
`include "handheld_bus_address_decoder_top_macros.svh"

module handheld_bus_address_decoder_top
    import hbad_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // command
    input  logic [1:0]         s_tuser,
    // address, access_bytes, write_data, prefetch, bg_mode, pc_in_bios, read_data
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // target, local_offset, out_bytes, out_data, bios_privileged, access_dropped,
    // return_data, zero fill
    output logic [TDATA_W-1:0] m_tdata
);

    logic             s1_valid_reg;
    cmd_t             s1_cmd_reg;
    logic [31:0]      s1_addr_reg;
    logic [2:0]       s1_bytes_reg;
    logic [31:0]      s1_wdata_reg;
    logic             s1_prefetch_reg;
    logic [2:0]       s1_mode_reg;
    logic             s1_priv_reg;
    logic [31:0]      s1_rdata_reg;

    logic             m_valid_reg;
    res_t             m_res_reg;
    res_t             res_next;

    logic [31:0]      latch_reg;
    logic [31:0]      latch_next;
    logic             pending_reg;
    logic             pending_next;

    logic             m_adv;
    logic             s1_adv;

    logic [7:0]       region;
    tgt_t             dec_tgt;
    logic [OFF_W-1:0] dec_off;
    logic [OFF_W-1:0] vram_rel;
    logic [OFF_W-1:0] vram_off;
    logic             bitmap;
    logic             hole;
    logic             byte_acc;
    logic             keep;
    logic             widen;
    logic [63:0]      rot_wide;

    assign m_adv    = !m_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && m_adv;
    assign s_tready = !s1_valid_reg || m_adv;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {RES_PAD'(0), m_res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            latch_reg    <= '0;
            pending_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (m_adv) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (s1_adv) begin
                latch_reg   <= latch_next;
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_cmd_reg      <= cmd_t'(s_tuser);
            s1_addr_reg     <= s_tdata[31:0];
            s1_bytes_reg    <= s_tdata[34:32];
            s1_wdata_reg    <= s_tdata[66:35];
            s1_prefetch_reg <= s_tdata[67];
            s1_mode_reg     <= s_tdata[70:68];
            s1_priv_reg     <= s_tdata[71];
            s1_rdata_reg    <= s_tdata[103:72];
        end
        if (s1_adv) begin
            m_res_reg <= res_next;
        end
    end

    assign region   = s1_addr_reg[31:24];
    assign bitmap   = (s1_mode_reg >= 3'd3) && (s1_mode_reg <= 3'd5);
    assign hole     = (s1_addr_reg >= VRAM_HOLE_LO) && (s1_addr_reg <= VRAM_HOLE_HI);
    assign byte_acc = (s1_bytes_reg == BYTE_SIZE);
    assign rot_wide = {latch_reg, latch_reg} >> {s1_addr_reg[1:0], 3'b000};

    // VRAM mirrors every mirror-size window; the top 32K of each window
    // folds back onto the 32K below it.
    assign vram_rel = OFF_W'(s1_addr_reg - VRAM_BASE) & VRAM_MASK;
    assign vram_off = (vram_rel >= VRAM_FOLD_START) ? (vram_rel - VRAM_FOLD_SIZE) : vram_rel;

    always_comb begin
        dec_tgt = TGT_NONE;
        dec_off = '0;
        unique case (region)
            REGION_EWRAM: begin
                dec_tgt = TGT_EWRAM;
                dec_off = s1_addr_reg[OFF_W-1:0] & EWRAM_MASK;
            end
            REGION_IWRAM: begin
                dec_tgt = TGT_IWRAM;
                dec_off = s1_addr_reg[OFF_W-1:0] & IWRAM_MASK;
            end
            REGION_IO: begin
                dec_tgt = TGT_IO;
                dec_off = s1_addr_reg[OFF_W-1:0] & IO_MASK;
            end
            REGION_PAL: begin
                dec_tgt = TGT_PAL;
                dec_off = s1_addr_reg[OFF_W-1:0] & PALETTE_MASK;
            end
            REGION_VRAM: begin
                dec_tgt = TGT_VRAM;
                dec_off = vram_off;
            end
            REGION_OAM: begin
                dec_tgt = TGT_OAM;
                dec_off = s1_addr_reg[OFF_W-1:0] & OAM_MASK;
            end
            // Each cartridge window spans two regions, so the offset keeps
            // the low region bit above the 24-bit address.
            REGION_CART0A, REGION_CART0B, REGION_CART1A, REGION_CART1B,
            REGION_CART2A, REGION_CART2B: begin
                dec_tgt = TGT_CART;
                dec_off = s1_addr_reg[OFF_W-1:0];
            end
            REGION_SRAMA, REGION_SRAMB: begin
                dec_tgt = TGT_SRAM;
                dec_off = s1_addr_reg[OFF_W-1:0] & SRAM_MASK;
            end
            default: begin
                dec_tgt = TGT_NONE;
                dec_off = '0;
            end
        endcase
    end

    always_comb begin
        res_next     = '0;
        latch_next   = latch_reg;
        pending_next = pending_reg;
        keep         = 1'b0;
        widen        = 1'b0;
        unique case (s1_cmd_reg)
            CMD_READ: begin
                if (region == REGION_BIOS) begin
                    if (s1_addr_reg <= BIOS_LIMIT) begin
                        res_next.target          = TGT_BIOS;
                        res_next.local_offset    = s1_addr_reg[OFF_W-1:0];
                        res_next.bios_privileged = s1_priv_reg;
                    end
                end else if (!(bitmap && hole)) begin
                    res_next.target       = dec_tgt;
                    res_next.local_offset = dec_off;
                end
                if (res_next.target != TGT_NONE) begin
                    res_next.out_bytes = s1_bytes_reg;
                    pending_next       = s1_prefetch_reg;
                end else begin
                    // Unrouted read: answer now, from open bus unless it is the hole.
                    pending_next            = 1'b0;
                    res_next.local_offset   = '0;
                    res_next.access_dropped = 1'b1;
                    if (!(bitmap && hole)) begin
                        res_next.return_data = rot_wide[31:0];
                    end
                end
            end
            CMD_WRITE: begin
                keep = (dec_tgt != TGT_NONE) && (dec_tgt != TGT_CART)
                    && !(dec_tgt == TGT_OAM && byte_acc);
                if (dec_tgt == TGT_PAL && byte_acc) begin
                    widen = 1'b1;
                end
                if (dec_tgt == TGT_VRAM) begin
                    if (bitmap) begin
                        if (hole) begin
                            keep = 1'b0;
                        end else if (byte_acc && s1_addr_reg >= OBJ_BITMAP_LO
                                     && s1_addr_reg <= OBJ_HI) begin
                            keep = 1'b0;
                        end else if (byte_acc && s1_addr_reg >= VRAM_BASE
                                     && s1_addr_reg <= BG_BITMAP_HI) begin
                            widen = 1'b1;
                        end
                    end else begin
                        if (byte_acc && s1_addr_reg >= OBJ_LO && s1_addr_reg <= OBJ_HI) begin
                            keep = 1'b0;
                        end else if (byte_acc && s1_addr_reg >= VRAM_BASE
                                     && s1_addr_reg <= BG_HI) begin
                            widen = 1'b1;
                        end
                    end
                end
                if (keep) begin
                    res_next.target = dec_tgt;
                    if (widen) begin
                        res_next.local_offset = {dec_off[OFF_W-1:1], 1'b0};
                        res_next.out_data     = {16'd0, s1_wdata_reg[7:0], s1_wdata_reg[7:0]};
                        res_next.out_bytes    = HALF_SIZE;
                    end else begin
                        res_next.local_offset = dec_off;
                        res_next.out_data     = s1_wdata_reg;
                        res_next.out_bytes    = s1_bytes_reg;
                    end
                end else begin
                    res_next.access_dropped = 1'b1;
                end
            end
            CMD_DATA: begin
                if (pending_reg) begin
                    latch_next   = s1_rdata_reg;
                    pending_next = 1'b0;
                end
            end
            default: begin
                latch_next   = latch_reg;
                pending_next = pending_reg;
            end
        endcase
    end

    `HBAD_ASSERT_IMPLY(a_full_pipe_stalls_input,
        s1_valid_reg && m_valid_reg && !m_tready, !s_tready)
    `HBAD_ASSERT_IMPLY(a_unrouted_result_empty,
        m_valid_reg && m_res_reg.target == TGT_NONE,
        m_res_reg.out_bytes == 3'd0 && m_res_reg.local_offset == '0
            && m_res_reg.out_data == '0)
    `HBAD_ASSERT_NEXT(a_data_clears_pending, s1_adv && s1_cmd_reg == CMD_DATA, !pending_reg)
    `HBAD_ASSERT_NEXT(a_latch_only_on_data, s1_adv && s1_cmd_reg != CMD_DATA, $stable(latch_reg))

endmodule
